>>> sv/bss_pkg.sv
// Package for the bubble sort swap counter: widths, default capacity and
// the sequencer state type. No dependencies.
package bss_pkg;

   localparam int DATA_W      = 32;
   localparam int SWAP_W      = 11;
   localparam int MAX_LEN_DEF = 64;

   localparam logic [SWAP_W-1:0] SWAP_SAT = '1;

   typedef enum logic [2:0] {
      S_COLLECT,
      S_PRIME,
      S_LOAD,
      S_RUN,
      S_FLUSH,
      S_EMIT_RD,
      S_EMIT_OUT
   } state_type;

endpackage

>>> sv/bss_req_if.sv
// Request channel of the bubble sort swap counter: one list element a beat.
// Depends on bss_pkg for the data width.
interface bss_req_if
   import bss_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

>>> sv/bss_rsp_if.sv
// Response channel of the bubble sort swap counter: one sorted element a beat.
// Depends on bss_pkg for the data and swap count widths.
interface bss_rsp_if
   import bss_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sorted_value;
   logic                     last_res;
   logic        [SWAP_W-1:0] swap_count;
   logic                     overflow;

   modport source (output valid, output sorted_value, output last_res,
                   output swap_count, output overflow, input ready);
   modport sink   (input valid, input sorted_value, input last_res,
                   input swap_count, input overflow, output ready);
endinterface

>>> sv/bubble_sort_swap_count.sv
// Sorting: after the last beat, an n-element list (n capped at MAX_LEN) sorts in
// passes; each pass of length hi loads entry 0, compares up to hi, then flushes.
// Throughput: one request beat a cycle while collecting; while emitting, each
// response beat is first read through the store's single read port, then held.
// Reset: synchronous, active high; clears the sequencer, count, swap total and
// overflow flag. The element store is not cleared.
module bubble_sort_swap_count
   import bss_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic          clock,
   input  logic          reset,
   bss_req_if.sink       req_bus,
   bss_rsp_if.source     rsp_bus
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;  // store index width
   localparam int CW = $clog2(MAX_LEN + 1);                  // element count width

   // Element store: one write and one registered read per cycle.
   logic [DATA_W-1:0] mem [MAX_LEN];

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [SWAP_W-1:0] swap_ff, swap_in;
   logic [AW-1:0]     hi_ff, hi_in;        // last index touched in the current pass
   logic [AW-1:0]     k_ff, k_in;          // compare index, then emit index
   logic [DATA_W-1:0] cur_ff, cur_in;      // value bubbling up through the pass
   logic [DATA_W-1:0] rd_data_ff;

   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [DATA_W-1:0] wr_data;

   logic              req_beat, rsp_beat;
   logic              last_step, last_beat;

   assign req_beat  = req_bus.valid && req_bus.ready;
   assign rsp_beat  = rsp_bus.valid && rsp_bus.ready;
   assign last_step = (k_ff == hi_ff - AW'(1));
   assign last_beat = ((CW'(k_ff) + CW'(1)) == count_ff);

   // Store access
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_COLLECT;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         swap_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         swap_ff    <= swap_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      k_ff   <= k_in;
      cur_ff <= cur_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_COLLECT: begin
            if (req_beat && req_bus.last) begin
               // a single element needs no pass
               state_in = (count_in == CW'(1)) ? S_EMIT_RD : S_PRIME;
            end
         end
         S_PRIME:   state_in = S_LOAD;
         S_LOAD:    state_in = S_RUN;
         S_RUN: begin
            if (last_step) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH:   state_in = (hi_ff == AW'(1)) ? S_EMIT_RD : S_LOAD;
         S_EMIT_RD: state_in = S_EMIT_OUT;
         S_EMIT_OUT: begin
            if (rsp_beat) begin
               state_in = last_beat ? S_COLLECT : S_EMIT_RD;
            end
         end
         default:   state_in = S_COLLECT;
      endcase
   end

   // Datapath control
   always_comb begin
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = cur_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      swap_in    = swap_ff;
      hi_in      = hi_ff;
      k_in       = k_ff;
      cur_in     = cur_ff;
      case (state_ff)
         S_COLLECT: begin
            if (req_beat) begin
               if (count_ff < CW'(MAX_LEN)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = req_bus.value;
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;   // store full: element lost
               end
               if (req_bus.last) begin
                  hi_in = AW'(count_in - CW'(1));
                  k_in  = '0;
               end
            end
         end
         S_PRIME: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         S_LOAD: begin
            cur_in  = rd_data_ff;
            rd_en   = 1'b1;
            rd_addr = AW'(1);
            k_in    = '0;
         end
         S_RUN: begin
            // rd_data_ff holds entry k+1; the smaller one settles at k
            wr_en   = 1'b1;
            wr_addr = k_ff;
            if ($signed(cur_ff) > $signed(rd_data_ff)) begin
               wr_data = rd_data_ff;
               if (swap_ff != SWAP_SAT) begin
                  swap_in = swap_ff + SWAP_W'(1);
               end
            end else begin
               wr_data = cur_ff;
               cur_in  = rd_data_ff;
            end
            if (!last_step) begin
               rd_en   = 1'b1;
               rd_addr = k_ff + AW'(2);
               k_in    = k_ff + AW'(1);
            end
         end
         S_FLUSH: begin
            // largest of the pass lands at hi; start the next pass unless hi is 1
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = cur_ff;
            if (hi_ff == AW'(1)) begin
               k_in = '0;
            end else begin
               hi_in   = hi_ff - AW'(1);
               rd_en   = 1'b1;
               rd_addr = '0;
            end
         end
         S_EMIT_RD: begin
            rd_en   = 1'b1;
            rd_addr = k_ff;
         end
         S_EMIT_OUT: begin
            if (rsp_beat) begin
               if (last_beat) begin
                  count_in   = '0;
                  swap_in    = '0;
                  dropped_in = 1'b0;
               end else begin
                  k_in = k_ff + AW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Channel outputs; payload comes straight from the read register
   always_comb begin
      req_bus.ready        = (state_ff == S_COLLECT);
      rsp_bus.valid        = (state_ff == S_EMIT_OUT);
      rsp_bus.sorted_value = $signed(rd_data_ff);
      rsp_bus.last_res     = last_beat;
      rsp_bus.swap_count   = swap_ff;
      rsp_bus.overflow     = dropped_ff;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LEN))
      else $error("element count above capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("store read and write hit the same entry");

   a_run_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (k_ff < hi_ff))
      else $error("compare index past end of pass");

   a_list_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_bus.last_res) |=> (count_ff == '0 && swap_ff == '0))
      else $error("list state not cleared after final beat");
`endif

endmodule
